### sv/assert_macros.svh
// assertion macros shared by the engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MBTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define MBTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/mbtc_pkg.sv
// shared constants and control types of the modbus tcp client engine
`timescale 1ns / 1ps
package mbtc_pkg;

  // input operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // transaction status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FAULT = 2'd1;
  localparam logic [1:0] STAT_EXC   = 2'd2;

  // output register load select
  localparam logic [1:0] EM_NONE   = 2'd0;
  localparam logic [1:0] EM_TX     = 2'd1;
  localparam logic [1:0] EM_WORD   = 2'd2;
  localparam logic [1:0] EM_STATUS = 2'd3;

  // protocol constants
  localparam logic [7:0]  FC_READ        = 8'd3;
  localparam logic [7:0]  FC_WRITE       = 8'd6;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
  localparam int          MAX_REGS_DEF   = 16;
  localparam int          WRITE_BODY_MAX = 8;
  localparam int          WRITE_BODY_OK  = 4;

  // controller to datapath
  typedef struct packed {
    logic       start;
    logic       hdr_wr;
    logic       body_wr;
    logic       tick_dec;
    logic       save_exc;
    logic       cnt_clr;
    logic       cnt_inc;
    logic [1:0] emit;
    logic [1:0] stat;
    logic       last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic tx_last;
    logic word_last;
    logic hdr_done;
    logic len_ok;
    logic body_done;
    logic id_ok;
    logic func_ok;
    logic is_read;
    logic rd_ok;
    logic wr_ok;
    logic cnt_zero;
    logic expire;
  } sts_t;

endpackage

### sv/mbtc_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module mbtc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/mbtc_ctrl.sv
// transaction controller state machine of the modbus tcp client engine
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbtc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_operation,
  output logic               in_stall,
  input  mbtc_pkg::sts_t     sts,
  output mbtc_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TX     = 3'd1;
  localparam logic [2:0] ST_HEADER = 3'd2;
  localparam logic [2:0] ST_BODY   = 3'd3;
  localparam logic [2:0] ST_WREAD  = 3'd4;
  localparam logic [2:0] ST_WOUT   = 3'd5;
  localparam logic [2:0] ST_STATUS = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept_st;
  logic       acc;

  assign accept_st = (state_r == ST_IDLE) || (state_r == ST_HEADER) || (state_r == ST_BODY);
  assign in_stall  = !(accept_st && sts.out_free);
  assign acc       = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && (in_operation == mbtc_pkg::OP_READ ||
                    in_operation == mbtc_pkg::OP_WRITE)) begin
          cmd.start   = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_TX;
        end
      end
      ST_TX: begin
        if (sts.out_free) begin
          cmd.emit    = mbtc_pkg::EM_TX;
          cmd.last    = sts.tx_last;
          cmd.cnt_inc = 1'b1;
          if (sts.tx_last) begin
            state_nxt = ST_HEADER;
          end
        end
      end
      ST_HEADER, ST_BODY: begin
        if (acc && in_operation == mbtc_pkg::OP_TICK) begin
          if (sts.expire) begin
            cmd.emit  = mbtc_pkg::EM_STATUS;
            cmd.stat  = mbtc_pkg::STAT_FAULT;
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.tick_dec = 1'b1;
          end
        end else if (acc && in_operation == mbtc_pkg::OP_BYTE) begin
          if (state_r == ST_HEADER) begin
            cmd.hdr_wr = 1'b1;
            if (sts.hdr_done) begin
              if (sts.len_ok) begin
                state_nxt = ST_BODY;
              end else begin
                cmd.emit  = mbtc_pkg::EM_STATUS;
                cmd.stat  = mbtc_pkg::STAT_FAULT;
                cmd.last  = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
          end else begin
            cmd.body_wr = 1'b1;
            if (sts.body_done) begin
              cmd.last  = 1'b1;
              state_nxt = ST_IDLE;
              priority if (!sts.id_ok) begin
                cmd.emit = mbtc_pkg::EM_STATUS;
                cmd.stat = mbtc_pkg::STAT_FAULT;
              end else if (!sts.func_ok) begin
                cmd.save_exc = 1'b1;
                cmd.emit     = mbtc_pkg::EM_STATUS;
                cmd.stat     = mbtc_pkg::STAT_EXC;
              end else if (sts.is_read && !sts.rd_ok) begin
                cmd.emit = mbtc_pkg::EM_STATUS;
                cmd.stat = mbtc_pkg::STAT_FAULT;
              end else if (sts.is_read && !sts.cnt_zero) begin
                // good read with data: stream the words first
                cmd.last    = 1'b0;
                cmd.cnt_clr = 1'b1;
                state_nxt   = ST_WREAD;
              end else if (sts.is_read || sts.wr_ok) begin
                cmd.emit = mbtc_pkg::EM_STATUS;
                cmd.stat = mbtc_pkg::STAT_OK;
              end else begin
                cmd.emit = mbtc_pkg::EM_STATUS;
                cmd.stat = mbtc_pkg::STAT_FAULT;
              end
            end
          end
        end
      end
      ST_WREAD: begin
        state_nxt = ST_WOUT;
      end
      ST_WOUT: begin
        if (sts.out_free) begin
          cmd.emit    = mbtc_pkg::EM_WORD;
          cmd.cnt_inc = 1'b1;
          state_nxt   = sts.word_last ? ST_STATUS : ST_WREAD;
        end
      end
      ST_STATUS: begin
        if (sts.out_free) begin
          cmd.emit  = mbtc_pkg::EM_STATUS;
          cmd.stat  = mbtc_pkg::STAT_OK;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MBTC_ASSERT_NXT(a_start_to_tx, clk, rst_n, cmd.start, state_r == ST_TX)
  `MBTC_ASSERT_NXT(a_last_word_to_status, clk, rst_n,
    (state_r == ST_WOUT) && sts.out_free && sts.word_last, state_r == ST_STATUS)
  `MBTC_ASSERT_IMP(a_emit_needs_room, clk, rst_n,
    cmd.emit != mbtc_pkg::EM_NONE, sts.out_free)

endmodule

### sv/mbtc_dpath.sv
// request, reply buffer, deadline and output register datapath
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbtc_dpath #(
  parameter int MAX_REGS = mbtc_pkg::MAX_REGS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mbtc_pkg::cmd_t cmd,
  output mbtc_pkg::sts_t sts,
  input  logic [1:0]     in_operation,
  input  logic [7:0]     in_unit_id,
  input  logic [15:0]    in_reg_addr,
  input  logic [15:0]    in_reg_count,
  input  logic [15:0]    in_write_value,
  input  logic [7:0]     in_rx_byte,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  output logic [15:0]    timeout,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_tx_byte,
  output logic [15:0]    out_reg_value,
  output logic [3:0]     out_reg_index,
  output logic [1:0]     out_status,
  output logic [7:0]     out_exception_code,
  output logic           out_last
);

  localparam int READ_BODY_MAX = 1 + 2 * MAX_REGS;
  localparam int BODY_MAX = (READ_BODY_MAX > mbtc_pkg::WRITE_BODY_MAX) ?
                            READ_BODY_MAX : mbtc_pkg::WRITE_BODY_MAX;
  localparam int BC_W   = $clog2(BODY_MAX + 1);
  localparam int WIDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int WC_W   = $clog2(MAX_REGS + 1);
  localparam int EC_W   = (WC_W > 4) ? WC_W : 4;
  localparam logic [15:0] READ_LIM  = 16'(READ_BODY_MAX);
  localparam logic [15:0] WRITE_LIM = 16'(mbtc_pkg::WRITE_BODY_MAX);

  // request side
  logic [15:0] tid_r;
  logic [15:0] sent_id_r;
  logic [7:0]  unit_r;
  logic [15:0] addr_r;
  logic [15:0] third_r;
  logic [15:0] count_r;
  logic        is_read_r;
  logic [15:0] timeout_r;
  logic [15:0] ticks_r;
  logic [7:0]  saved_exc_r;

  // reply side
  logic [2:0]      hdr_cnt_r;
  logic [7:0]      id_hi_r;
  logic [7:0]      id_lo_r;
  logic [7:0]      len_hi_r;
  logic [7:0]      len_lo_r;
  logic [7:0]      fn_r;
  logic [BC_W-1:0] body_len_r;
  logic [BC_W-1:0] body_cnt_r;
  logic [7:0]      byte_cnt_r;
  logic [7:0]      hi_r;
  logic [EC_W-1:0] emit_cnt_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_tx_r;
  logic [15:0] out_val_r;
  logic [3:0]  out_idx_r;
  logic [1:0]  out_stat_r;
  logic [7:0]  out_exc_r;
  logic        out_last_r;

  logic [15:0]     len;
  logic [15:0]     len_m2;
  logic [BC_W-2:0] widx;
  logic            word_we;
  logic [15:0]     ram_rdata;
  logic [7:0]      body0;
  logic [16:0]     twice;
  logic [7:0]      frame_byte;
  logic [7:0]      exc_val;
  logic            out_free;

  assign len    = {len_hi_r, len_lo_r};
  assign len_m2 = len - 16'd2;
  assign widx   = body_cnt_r[BC_W-1:1] - (BC_W-1)'(1);
  assign word_we = cmd.body_wr && !body_cnt_r[0] && (body_cnt_r != '0) &&
                   (widx < (BC_W-1)'(MAX_REGS));
  assign body0  = (body_cnt_r == '0) ? in_rx_byte : byte_cnt_r;
  assign twice  = {count_r, 1'b0};
  assign exc_val = cmd.save_exc ? body0 : saved_exc_r;
  assign out_free = !out_valid_r || !out_stall;

  mbtc_ram #(
    .WIDTH (16),
    .DEPTH (MAX_REGS)
  ) u_words (
    .clk   (clk),
    .we    (word_we),
    .waddr (widx[WIDX_W-1:0]),
    .wdata ({hi_r, in_rx_byte}),
    .raddr (emit_cnt_r[WIDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.out_free  = out_free;
    sts.tx_last   = emit_cnt_r == EC_W'(11);
    sts.word_last = (16'(emit_cnt_r) + 16'd1) == count_r;
    sts.hdr_done  = hdr_cnt_r == 3'd7;
    sts.len_ok    = (len >= 16'd3) && (len_m2 <= (is_read_r ? READ_LIM : WRITE_LIM));
    sts.body_done = ({1'b0, body_cnt_r} + (BC_W+1)'(1)) == {1'b0, body_len_r};
    sts.id_ok     = {id_hi_r, id_lo_r} == sent_id_r;
    sts.func_ok   = fn_r == (is_read_r ? mbtc_pkg::FC_READ : mbtc_pkg::FC_WRITE);
    sts.is_read   = is_read_r;
    sts.rd_ok     = ({9'd0, body0} == twice) && (17'(body_len_r) == twice + 17'd1);
    sts.wr_ok     = body_len_r == BC_W'(mbtc_pkg::WRITE_BODY_OK);
    sts.cnt_zero  = count_r == 16'd0;
    sts.expire    = ticks_r <= 16'd1;
  end

  always_comb begin
    unique case (emit_cnt_r)
      EC_W'(0):  frame_byte = sent_id_r[15:8];
      EC_W'(1):  frame_byte = sent_id_r[7:0];
      EC_W'(5):  frame_byte = 8'd6;
      EC_W'(6):  frame_byte = unit_r;
      EC_W'(7):  frame_byte = is_read_r ? mbtc_pkg::FC_READ : mbtc_pkg::FC_WRITE;
      EC_W'(8):  frame_byte = addr_r[15:8];
      EC_W'(9):  frame_byte = addr_r[7:0];
      EC_W'(10): frame_byte = third_r[15:8];
      EC_W'(11): frame_byte = third_r[7:0];
      default:   frame_byte = 8'd0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tid_r       <= 16'd1;
      timeout_r   <= mbtc_pkg::TIMEOUT_RESET;
      ticks_r     <= 16'd0;
      saved_exc_r <= 8'd0;
      hdr_cnt_r   <= 3'd0;
      body_cnt_r  <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (cmd.start) begin
        tid_r     <= tid_r + 16'd1;
        ticks_r   <= timeout_r;
        hdr_cnt_r <= 3'd0;
      end else if (cmd.tick_dec) begin
        ticks_r <= ticks_r - 16'd1;
      end
      if (cmd.hdr_wr) begin
        hdr_cnt_r <= hdr_cnt_r + 3'd1;
      end
      if (cmd.hdr_wr && sts.hdr_done) begin
        body_cnt_r <= '0;
      end else if (cmd.body_wr) begin
        body_cnt_r <= body_cnt_r + BC_W'(1);
      end
      if (cmd.save_exc) begin
        saved_exc_r <= body0;
      end
      if (cmd.cnt_clr) begin
        emit_cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        emit_cnt_r <= emit_cnt_r + EC_W'(1);
      end
      out_valid_r <= (cmd.emit != mbtc_pkg::EM_NONE) || (out_valid_r && out_stall);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sent_id_r <= tid_r;
      unit_r    <= in_unit_id;
      addr_r    <= in_reg_addr;
      is_read_r <= in_operation == mbtc_pkg::OP_READ;
      count_r   <= (in_operation == mbtc_pkg::OP_READ) ? in_reg_count : 16'd0;
      third_r   <= (in_operation == mbtc_pkg::OP_READ) ? in_reg_count : in_write_value;
    end
    if (cmd.hdr_wr) begin
      unique case (hdr_cnt_r)
        3'd0:    id_hi_r  <= in_rx_byte;
        3'd1:    id_lo_r  <= in_rx_byte;
        3'd4:    len_hi_r <= in_rx_byte;
        3'd5:    len_lo_r <= in_rx_byte;
        3'd7:    fn_r     <= in_rx_byte;
        default: ;
      endcase
      if (sts.hdr_done) begin
        body_len_r <= len_m2[BC_W-1:0];
      end
    end
    if (cmd.body_wr) begin
      if (body_cnt_r == '0) begin
        byte_cnt_r <= in_rx_byte;
      end
      if (body_cnt_r[0]) begin
        hi_r <= in_rx_byte;
      end
    end
    if (cmd.emit != mbtc_pkg::EM_NONE) begin
      out_tx_r   <= 8'd0;
      out_val_r  <= 16'd0;
      out_idx_r  <= 4'd0;
      out_stat_r <= mbtc_pkg::STAT_OK;
      out_exc_r  <= 8'd0;
      out_last_r <= cmd.last;
      unique case (cmd.emit)
        mbtc_pkg::EM_TX: begin
          out_kind_r <= mbtc_pkg::KIND_TX;
          out_tx_r   <= frame_byte;
        end
        mbtc_pkg::EM_WORD: begin
          out_kind_r <= mbtc_pkg::KIND_WORD;
          out_val_r  <= ram_rdata;
          out_idx_r  <= emit_cnt_r[3:0];
        end
        default: begin
          out_kind_r <= mbtc_pkg::KIND_STATUS;
          out_stat_r <= cmd.stat;
          out_exc_r  <= exc_val;
        end
      endcase
    end
  end

  assign timeout            = timeout_r;
  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_tx_byte        = out_tx_r;
  assign out_reg_value      = out_val_r;
  assign out_reg_index      = out_idx_r;
  assign out_status         = out_stat_r;
  assign out_exception_code = out_exc_r;
  assign out_last           = out_last_r;

  `MBTC_ASSERT_IMP(a_word_in_range, clk, rst_n,
    cmd.emit == mbtc_pkg::EM_WORD, 16'(emit_cnt_r) < count_r)

endmodule

### sv/modbus_tcp_client_engine.sv
// a start blocks input until all 12 request frame bytes are out; results are registered
// throughput: one reply byte or tick per cycle while the result register is free
// a good read streams each word through ram read then output states, plus one status
// the request frame is built by a byte counter and the words leave a registered-read ram
// reset (rst_n low, synchronous): idle, transaction id 1, timeout 500, no result pending
`timescale 1ns / 1ps
module modbus_tcp_client_engine #(
  parameter int MAX_REGS = mbtc_pkg::MAX_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request and reply input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_unit_id,
  input  logic [15:0] in_reg_addr,
  input  logic [15:0] in_reg_count,
  input  logic [15:0] in_write_value,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [15:0] out_reg_value,
  output logic [3:0]  out_reg_index,
  output logic [1:0]  out_status,
  output logic [7:0]  out_exception_code,
  output logic        out_last,
  // apb-style configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mbtc_pkg::cmd_t cmd;
  mbtc_pkg::sts_t sts;
  logic           cfg_we;
  logic [15:0]    timeout;

  // one register only, the timeout; the byte offset within it is not decoded
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[1:0] == cfg_paddr);
  assign cfg_prdata = {16'd0, timeout};

  // controller: sequences start, header, body and the output runs of a transaction
  mbtc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // datapath: request fields, reply header and body capture, deadline and output register
  mbtc_dpath #(
    .MAX_REGS (MAX_REGS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_unit_id         (in_unit_id),
    .in_reg_addr        (in_reg_addr),
    .in_reg_count       (in_reg_count),
    .in_write_value     (in_write_value),
    .in_rx_byte         (in_rx_byte),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_pwdata[15:0]),
    .timeout            (timeout),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_tx_byte        (out_tx_byte),
    .out_reg_value      (out_reg_value),
    .out_reg_index      (out_reg_index),
    .out_status         (out_status),
    .out_exception_code (out_exception_code),
    .out_last           (out_last)
  );

endmodule
